/* rtl/core/lpht_pkg.sv */
// Shared types, sizes and codes for the linear-probe hash table.
package lpht_pkg;

    localparam int CAPACITY = 256;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int FUNC_W   = 2;
    localparam int KEY_W    = 32;
    localparam int HASH_W   = 32;
    localparam int VAL_W    = 64;
    localparam int STAT_W   = 3;
    localparam int FILL_W   = 9;

    localparam logic [FILL_W-1:0] MAX_FILL_RST = 9'd192;

    localparam logic [FUNC_W-1:0] FUNC_PUT    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_UPDATED   = 3'd1;
    localparam logic [STAT_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_REMOVED   = 3'd4;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_COMMIT
    } state_t;

    typedef struct packed {
        logic start;
        logic probe;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic func_ok;
        logic stop;
        logic out_free;
    } sts_t;

endpackage

/* rtl/core/linear_probe_hash_table.sv */
// Linear-probe hash table, top level: one request in, one result out per request.
// Open-addressing key/value table of lpht_pkg::CAPACITY slots. A request is taken
// when s_valid and s_ready are high; probing starts at the low bits of s_key_hash
// and walks forward one slot per cycle, wrapping, until it hits the key, an empty
// slot, or has visited every slot. A request passes through accept, probe and commit,
// with one key/value memory read per visited slot, and commit waits until the output
// register is free; s_ready returns the cycle after commit. An unused operation code
// skips the probe state. The result sits in an output register, so the next request
// is accepted while it waits for m_ready. Removed entries become tombstones that a
// later put reuses; a put of a new key is answered full when the live count has
// reached max_fill or no free slot was seen. Slot occupancy bits clear at once on
// reset; there is no clearing pass. Write max_fill only while idle.
module linear_probe_hash_table (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [lpht_pkg::FUNC_W-1:0]   s_func,
    input  logic [lpht_pkg::KEY_W-1:0]    s_key_id,
    input  logic [lpht_pkg::HASH_W-1:0]   s_key_hash,
    input  logic [lpht_pkg::VAL_W-1:0]    s_value_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lpht_pkg::STAT_W-1:0]   m_status,
    output logic [lpht_pkg::VAL_W-1:0]    m_value_out,
    input  logic                          cfg_wr_en,
    input  logic [lpht_pkg::FILL_W-1:0]   cfg_wr_data
);

    lpht_pkg::cmd_t cmd;
    lpht_pkg::sts_t sts;

    lpht_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lpht_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .s_func      (s_func),
        .s_key_id    (s_key_id),
        .s_key_hash  (s_key_hash),
        .s_value_in  (s_value_in),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_value_out (m_value_out)
    );

endmodule

/* rtl/core/lpht_ctrl.sv */
// Request sequencer: accept, probe, commit.
module lpht_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  lpht_pkg::sts_t    sts,
    output lpht_pkg::cmd_t    cmd
);

    lpht_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lpht_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lpht_pkg::S_IDLE: begin
                if (s_valid) begin
                    // unused operation codes skip the search
                    state_next = sts.func_ok ? lpht_pkg::S_PROBE : lpht_pkg::S_COMMIT;
                end
            end
            lpht_pkg::S_PROBE: begin
                if (sts.stop) begin
                    state_next = lpht_pkg::S_COMMIT;
                end
            end
            lpht_pkg::S_COMMIT: begin
                if (sts.out_free) begin
                    state_next = lpht_pkg::S_IDLE;
                end
            end
            default: state_next = lpht_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        cmd.start  = 1'b0;
        cmd.probe  = 1'b0;
        cmd.commit = 1'b0;
        unique case (state_reg)
            lpht_pkg::S_IDLE: begin
                s_ready   = 1'b1;
                cmd.start = s_valid;
            end
            lpht_pkg::S_PROBE: begin
                cmd.probe = 1'b1;
            end
            lpht_pkg::S_COMMIT: begin
                cmd.commit = sts.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/core/lpht_dp.sv */
// Table storage, probe evaluation, commit logic and result register.
module lpht_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lpht_pkg::cmd_t                cmd,
    output lpht_pkg::sts_t                sts,
    input  logic [lpht_pkg::FUNC_W-1:0]   s_func,
    input  logic [lpht_pkg::KEY_W-1:0]    s_key_id,
    input  logic [lpht_pkg::HASH_W-1:0]   s_key_hash,
    input  logic [lpht_pkg::VAL_W-1:0]    s_value_in,
    input  logic                          cfg_wr_en,
    input  logic [lpht_pkg::FILL_W-1:0]   cfg_wr_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lpht_pkg::STAT_W-1:0]   m_status,
    output logic [lpht_pkg::VAL_W-1:0]    m_value_out
);

    localparam int IW = lpht_pkg::IDX_W;

    // storage
    logic [lpht_pkg::KEY_W-1:0] key_mem [lpht_pkg::CAPACITY];
    logic [lpht_pkg::VAL_W-1:0] val_mem [lpht_pkg::CAPACITY];
    logic                       tomb_mem [lpht_pkg::CAPACITY];
    logic [lpht_pkg::CAPACITY-1:0] used_reg;

    // request
    logic [lpht_pkg::FUNC_W-1:0] func_reg;
    logic [lpht_pkg::KEY_W-1:0]  key_reg;
    logic [lpht_pkg::VAL_W-1:0]  value_reg;

    // probe
    logic [IW-1:0]              addr_reg;
    logic [IW-1:0]              rd_idx_reg;
    logic [IW-1:0]              eval_cnt_reg;
    logic [lpht_pkg::KEY_W-1:0] rd_key_reg;
    logic [lpht_pkg::VAL_W-1:0] rd_val_reg;
    logic                       rd_tomb_reg;
    logic                       rd_used_reg;
    logic                       data_vld_reg;

    // search outcome
    logic                       found_reg;
    logic [IW-1:0]              hit_idx_reg;
    logic [lpht_pkg::VAL_W-1:0] found_val_reg;
    logic                       free_vld_reg;
    logic [IW-1:0]              free_idx_reg;

    logic [lpht_pkg::CNT_W-1:0]  live_count_reg;
    logic [lpht_pkg::FILL_W-1:0] max_fill_reg;

    logic                        m_valid_reg;
    logic [lpht_pkg::STAT_W-1:0] m_status_reg;
    logic [lpht_pkg::VAL_W-1:0]  m_value_reg;

    logic eval, slot_empty, slot_tomb, slot_live, key_match, last_slot, take_free;

    logic [lpht_pkg::STAT_W-1:0] status_c;
    logic [lpht_pkg::VAL_W-1:0]  value_c;
    logic                        wr_key, wr_val, wr_tomb, tomb_bit, do_insert, do_remove;
    logic [IW-1:0]               wr_addr;
    logic                        at_limit;

    assign sts.func_ok  = (s_func == lpht_pkg::FUNC_PUT) || (s_func == lpht_pkg::FUNC_LOOKUP) ||
                          (s_func == lpht_pkg::FUNC_REMOVE);
    assign sts.out_free = !m_valid_reg || m_ready;

    assign eval       = cmd.probe && data_vld_reg;
    assign slot_empty = !rd_used_reg;
    assign slot_tomb  = rd_used_reg && rd_tomb_reg;
    assign slot_live  = rd_used_reg && !rd_tomb_reg;
    assign key_match  = slot_live && (rd_key_reg == key_reg);
    assign last_slot  = (eval_cnt_reg == IW'(lpht_pkg::CAPACITY - 1));
    assign sts.stop   = eval && (slot_empty || key_match || last_slot);
    assign take_free  = eval && !free_vld_reg && (slot_empty || slot_tomb);

    assign at_limit = (32'(live_count_reg) >= 32'(max_fill_reg));

    // decide result and table update
    always_comb begin
        status_c  = lpht_pkg::ST_NOT_FOUND;
        value_c   = '0;
        wr_key    = 1'b0;
        wr_val    = 1'b0;
        wr_tomb   = 1'b0;
        tomb_bit  = 1'b0;
        do_insert = 1'b0;
        do_remove = 1'b0;
        wr_addr   = found_reg ? hit_idx_reg : free_idx_reg;
        unique case (func_reg)
            lpht_pkg::FUNC_PUT: begin
                if (found_reg) begin
                    status_c = lpht_pkg::ST_UPDATED;
                    wr_val   = 1'b1;
                end else if (at_limit || !free_vld_reg) begin
                    status_c = lpht_pkg::ST_FULL;
                end else begin
                    status_c  = lpht_pkg::ST_INSERTED;
                    wr_key    = 1'b1;
                    wr_val    = 1'b1;
                    wr_tomb   = 1'b1;
                    do_insert = 1'b1;
                end
            end
            lpht_pkg::FUNC_LOOKUP: begin
                if (found_reg) begin
                    status_c = lpht_pkg::ST_FOUND;
                    value_c  = found_val_reg;
                end
            end
            lpht_pkg::FUNC_REMOVE: begin
                if (found_reg) begin
                    status_c  = lpht_pkg::ST_REMOVED;
                    wr_tomb   = 1'b1;
                    tomb_bit  = 1'b1;
                    do_remove = 1'b1;
                end
            end
            default: begin
                status_c = lpht_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    // memories: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.commit && wr_key) begin
            key_mem[wr_addr] <= key_reg;
        end
        rd_key_reg <= key_mem[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && wr_val) begin
            val_mem[wr_addr] <= value_reg;
        end
        rd_val_reg <= val_mem[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && wr_tomb) begin
            tomb_mem[wr_addr] <= tomb_bit;
        end
        rd_tomb_reg <= tomb_mem[addr_reg];
    end

    // payload registers
    always_ff @(posedge aclk) begin
        rd_used_reg <= used_reg[addr_reg];
        rd_idx_reg  <= addr_reg;
        if (cmd.start) begin
            func_reg  <= s_func;
            key_reg   <= s_key_id;
            value_reg <= s_value_in;
            addr_reg  <= s_key_hash[IW-1:0];
        end else if (cmd.probe) begin
            addr_reg <= addr_reg + 1'b1;
        end
        if (eval && key_match) begin
            hit_idx_reg   <= rd_idx_reg;
            found_val_reg <= rd_val_reg;
        end
        if (take_free) begin
            free_idx_reg <= rd_idx_reg;
        end
        if (cmd.commit) begin
            m_status_reg <= status_c;
            m_value_reg  <= value_c;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg       <= '0;
            data_vld_reg   <= 1'b0;
            eval_cnt_reg   <= '0;
            found_reg      <= 1'b0;
            free_vld_reg   <= 1'b0;
            live_count_reg <= '0;
            max_fill_reg   <= lpht_pkg::MAX_FILL_RST;
            m_valid_reg    <= 1'b0;
        end else begin
            data_vld_reg <= cmd.probe;
            if (cfg_wr_en) begin
                max_fill_reg <= cfg_wr_data;
            end
            if (cmd.start) begin
                eval_cnt_reg <= '0;
                found_reg    <= 1'b0;
                free_vld_reg <= 1'b0;
            end else if (eval) begin
                eval_cnt_reg <= eval_cnt_reg + 1'b1;
                if (key_match) begin
                    found_reg <= 1'b1;
                end
                if (take_free) begin
                    free_vld_reg <= 1'b1;
                end
            end
            if (cmd.commit) begin
                if (do_insert) begin
                    used_reg[wr_addr] <= 1'b1;
                    live_count_reg    <= live_count_reg + 1'b1;
                end else if (do_remove && (live_count_reg != '0)) begin
                    live_count_reg <= live_count_reg - 1'b1;
                end
            end
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_value_out = m_value_reg;

endmodule

/* rtl/core/lpht_checker.sv */
// Port-level checks for the linear-probe hash table, bound to the top level.
module lpht_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [lpht_pkg::STAT_W-1:0]   m_status,
    input logic [lpht_pkg::VAL_W-1:0]    m_value_out
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_value_out))
        else $error("result changed while stalled");

    // only a found lookup returns data
    a_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != lpht_pkg::ST_FOUND) |-> m_value_out == '0)
        else $error("nonzero value on a status other than found");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= lpht_pkg::ST_FULL)
        else $error("status code out of range");

    // one request in flight: no accept right after an accept
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in flight");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_status    (m_status),
    .m_value_out (m_value_out)
);
